// ----- design/akc_pkg.sv -----
`default_nettype none

package akc_pkg;

  // Field widths
  localparam int unsigned SampleW  = 12;
  localparam int unsigned WindowW  = 12;
  localparam int unsigned MissW    = 16;
  localparam int unsigned CountW   = 19;
  localparam int unsigned ButtonW  = 2;
  localparam int unsigned CfgDataW = 19;
  localparam int unsigned CfgIdxW  = 3;

  // Saturation value of the held counter
  localparam logic [CountW-1:0] HeldMax = {CountW{1'b1}};

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegReleaseLevel = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMatchWindow  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMissLimit    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMinHeld      = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLongHeld     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMaxSamples   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegLevelOne     = 3'd6;
  localparam logic [CfgIdxW-1:0] RegLevelTwo     = 3'd7;

  // Register reset values
  localparam logic [SampleW-1:0] RstReleaseLevel = 12'd3800;
  localparam logic [WindowW-1:0] RstMatchWindow  = 12'd150;
  localparam logic [MissW-1:0]   RstMissLimit    = 16'd1000;
  localparam logic [CountW-1:0]  RstMinHeld      = 19'd100;
  localparam logic [CountW-1:0]  RstLongHeld     = 19'd15000;
  localparam logic [CountW-1:0]  RstMaxSamples   = 19'd500000;
  localparam logic [SampleW-1:0] RstLevelOne     = 12'd500;
  localparam logic [SampleW-1:0] RstLevelTwo     = 12'd2000;

  // Button codes
  localparam logic [ButtonW-1:0] BtnSelect = 2'd0;
  localparam logic [ButtonW-1:0] BtnUp     = 2'd1;
  localparam logic [ButtonW-1:0] BtnDown   = 2'd2;

  // Live configuration handed to the core
  typedef struct packed {
    logic [SampleW-1:0] release_level;
    logic [WindowW-1:0] match_window;
    logic [MissW-1:0]   miss_limit;
    logic [CountW-1:0]  min_held;
    logic [CountW-1:0]  long_held;
    logic [CountW-1:0]  max_samples;
    logic [SampleW-1:0] level_one;
    logic [SampleW-1:0] level_two;
  } cfg_t;

endpackage

`default_nettype wire

// ----- design/akc_sample_if.sv -----
`default_nettype none

interface akc_sample_if
  import akc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ----- design/akc_result_if.sv -----
`default_nettype none

interface akc_result_if
  import akc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [ButtonW-1:0] button;
  logic               long_press;

  modport source (output valid, output button, output long_press, input ready);
  modport sink   (input valid, input button, input long_press, output ready);
endinterface

`default_nettype wire

// ----- design/akc_cfg.sv -----
`default_nettype none

module akc_cfg
  import akc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q;

  // Register file, written one register per word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.release_level <= RstReleaseLevel;
      cfg_q.match_window  <= RstMatchWindow;
      cfg_q.miss_limit    <= RstMissLimit;
      cfg_q.min_held      <= RstMinHeld;
      cfg_q.long_held     <= RstLongHeld;
      cfg_q.max_samples   <= RstMaxSamples;
      cfg_q.level_one     <= RstLevelOne;
      cfg_q.level_two     <= RstLevelTwo;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegReleaseLevel: cfg_q.release_level <= cfg_data_i[SampleW-1:0];
        RegMatchWindow:  cfg_q.match_window  <= cfg_data_i[WindowW-1:0];
        RegMissLimit:    cfg_q.miss_limit    <= cfg_data_i[MissW-1:0];
        RegMinHeld:      cfg_q.min_held      <= cfg_data_i[CountW-1:0];
        RegLongHeld:     cfg_q.long_held     <= cfg_data_i[CountW-1:0];
        RegMaxSamples:   cfg_q.max_samples   <= cfg_data_i[CountW-1:0];
        RegLevelOne:     cfg_q.level_one     <= cfg_data_i[SampleW-1:0];
        RegLevelTwo:     cfg_q.level_two     <= cfg_data_i[SampleW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- design/akc_core.sv -----
`default_nettype none

module akc_core
  import akc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cfg_t      cfg_i,
  akc_sample_if.sink     in_if,
  akc_result_if.source   out_if
);

  typedef enum logic [1:0] {
    PhIdle   = 2'd0,
    PhSample = 2'd1,
    PhWait   = 2'd2
  } phase_e;

  // Input register
  logic               s1_valid_q;
  logic [SampleW-1:0] s1_sample_q;

  // Press state
  phase_e             phase_q, phase_d;
  logic [SampleW-1:0] ref_q, ref_d;
  logic [CountW-1:0]  held_q, held_d;
  logic [MissW-1:0]   miss_q, miss_d;
  logic [CountW-1:0]  seen_q, seen_d;

  // Result register
  logic               out_valid_q;
  logic [ButtonW-1:0] button_q, button_d;
  logic               long_q, long_d;
  logic               emit;

  logic               proc_go;
  logic               hit;
  logic [SampleW-1:0] drop;
  logic [MissW-1:0]   miss_next;
  logic [CountW-1:0]  held_next;
  logic [CountW:0]    seen_inc;

  // The registered word is processed when the result register can take a word
  assign proc_go     = s1_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !s1_valid_q || proc_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      s1_sample_q <= in_if.sample;
    end
  end

  // Hit test: at or below the reference and less than the window below it
  assign drop      = ref_q - s1_sample_q;
  assign hit       = (s1_sample_q <= ref_q) && (drop < cfg_i.match_window);
  assign miss_next = hit ? miss_q : miss_q - MissW'(1);
  assign held_next = (hit && (held_q != HeldMax)) ? held_q + CountW'(1) : held_q;
  assign seen_inc  = {1'b0, seen_q} + (CountW+1)'(1);

  // Next press state and result
  always_comb begin
    phase_d  = phase_q;
    ref_d    = ref_q;
    held_d   = held_q;
    miss_d   = miss_q;
    seen_d   = seen_q;
    emit     = 1'b0;
    button_d = BtnDown;
    long_d   = (held_q >= cfg_i.long_held);
    if (cfg_i.level_two > ref_q) begin
      button_d = BtnUp;
    end
    if (cfg_i.level_one > ref_q) begin
      button_d = BtnSelect;
    end
    case (phase_q)
      PhSample: begin
        held_d = held_next;
        miss_d = miss_next;
        if (miss_next == '0) begin
          phase_d = (held_next < cfg_i.min_held) ? PhIdle : PhWait;
        end else begin
          seen_d = seen_inc[CountW-1:0];
          if (seen_inc >= {1'b0, cfg_i.max_samples}) begin
            phase_d = PhWait;
          end
        end
      end
      PhWait: begin
        if (s1_sample_q >= cfg_i.release_level) begin
          emit    = 1'b1;
          phase_d = PhIdle;
        end
      end
      default: begin
        // idle, and the unused code
        phase_d = PhIdle;
        if (s1_sample_q <= cfg_i.release_level) begin
          ref_d   = s1_sample_q;
          held_d  = '0;
          miss_d  = cfg_i.miss_limit;
          seen_d  = '0;
          phase_d = PhSample;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      ref_q   <= '0;
      held_q  <= '0;
      miss_q  <= '0;
      seen_q  <= '0;
    end else if (proc_go) begin
      phase_q <= phase_d;
      ref_q   <= ref_d;
      held_q  <= held_d;
      miss_q  <= miss_d;
      seen_q  <= seen_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_go) begin
      out_valid_q <= emit;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_go && emit) begin
      button_q <= button_d;
      long_q   <= long_d;
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.button     = button_q;
  assign out_if.long_press = long_q;

  // A word leaves only after a release seen in the wait phase
  a_emit_from_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(phase_q) == PhWait)
    else $error("result word without a wait phase");

  // A release in the wait phase always loads a result
  a_release_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_go && phase_q == PhWait && s1_sample_q >= cfg_i.release_level)
      |=> out_valid_q && phase_q == PhIdle)
    else $error("release in wait phase lost");

  // While sampling, held samples never outnumber counted samples
  a_held_le_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhSample |-> held_q <= seen_q)
    else $error("held count above sample count");

  // Sampling never runs past the sample limit
  a_seen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhSample && $stable(cfg_i.max_samples)) |-> seen_q < cfg_i.max_samples
      || seen_q == '0)
    else $error("sample count past limit");

endmodule

`default_nettype wire

// ----- design/adc_ladder_key_classifier_unit.sv -----
`default_nettype none

// Resistor-ladder keypad decoder. Takes one 12-bit ADC word per cycle on
// in_if while no result waits unread (see below) and delivers at most
// one word per press on out_if: the button chosen by the reference level
// latched at press start, and a long-press flag. A sample is held in an
// input register, runs through the press state logic and any result lands
// in an output register, from which the result word is valid on out_if.
// While a result waits unread, one more sample is taken into the input
// register; the input then stalls until the result word is read.
// Registers are to be written through cfg_we_i / cfg_idx_i / cfg_data_i
// only while no press is in progress; the block does not enforce this.

module adc_ladder_key_classifier_unit
  import akc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  akc_sample_if.sink               in_if,
  akc_result_if.source             out_if
);

  cfg_t cfg;

  // Configuration registers
  akc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Press tracking and result register
  akc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_if  (in_if),
    .out_if (out_if)
  );

endmodule

`default_nettype wire
